// ===== hw/rtl/xcfp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package xcfp_pkg;

   localparam logic [7:0] HDR_FIRST  = 8'h55;
   localparam logic [7:0] HDR_SECOND = 8'hAA;
   localparam logic [7:0] FUNC_LED   = 8'h06;

   typedef struct packed {
      logic [7:0] func_code;
      logic [2:0] data_length;
      logic       led_cmd;
      logic [7:0] led_index;
      logic       led_on;
   } rsp_type;

   typedef struct packed {
      logic    valid;
      rsp_type data;
   } result_type;

endpackage

`default_nettype wire

// ===== hw/rtl/xcfp_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none

module xcfp_parser
   import xcfp_pkg::*;
#(
   parameter int MAX_DATA_LEN = 7
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       take,
   input  wire logic [7:0] rx_byte,
   output result_type      result
);

   localparam int LEN_W = $clog2(MAX_DATA_LEN + 1);

   localparam logic [2:0] PH_HUNT = 3'd0;
   localparam logic [2:0] PH_HDR2 = 3'd1;
   localparam logic [2:0] PH_LEN  = 3'd2;
   localparam logic [2:0] PH_DATA = 3'd3;
   localparam logic [2:0] PH_SUM  = 3'd4;

   logic [2:0]       phase_ff,     phase_in;
   logic [LEN_W-1:0] frame_len_ff, frame_len_in;
   logic [LEN_W-1:0] count_ff,     count_in;
   logic [7:0]       xor_ff,       xor_in;
   logic [7:0]       func_ff,      func_in;
   logic [7:0]       led_num_ff,   led_num_in;
   logic [7:0]       led_state_ff, led_state_in;

   logic [LEN_W-1:0] count_inc;
   logic [LEN_W+2:0] len_ext;
   logic             led;

   assign count_inc = count_ff + LEN_W'(1);
   assign len_ext   = {3'b000, frame_len_ff};
   assign led       = (func_ff == FUNC_LED) && (frame_len_ff >= LEN_W'(3));

   always_comb begin
      phase_in     = phase_ff;
      frame_len_in = frame_len_ff;
      count_in     = count_ff;
      xor_in       = xor_ff;
      func_in      = func_ff;
      led_num_in   = led_num_ff;
      led_state_in = led_state_ff;

      result.valid            = 1'b0;
      result.data.func_code   = func_ff;
      result.data.data_length = len_ext[2:0];
      result.data.led_cmd     = led;
      result.data.led_index   = led ? led_num_ff : 8'h00;
      result.data.led_on      = led && (led_state_ff != 8'h00);

      if (take) begin
         unique case (phase_ff)
            PH_HDR2: begin
               if (rx_byte == HDR_SECOND) begin
                  xor_in   = xor_ff ^ rx_byte;
                  phase_in = PH_LEN;
               end else begin
                  phase_in = PH_HUNT;
                  xor_in   = 8'h00;
               end
            end
            PH_LEN: begin
               if ({1'b0, rx_byte} > 9'(MAX_DATA_LEN)) begin
                  phase_in = PH_HUNT;
                  xor_in   = 8'h00;
               end else begin
                  frame_len_in = rx_byte[LEN_W-1:0];
                  count_in     = '0;
                  func_in      = 8'h00;
                  led_num_in   = 8'h00;
                  led_state_in = 8'h00;
                  xor_in       = xor_ff ^ rx_byte;
                  phase_in     = (rx_byte == 8'h00) ? PH_SUM : PH_DATA;
               end
            end
            PH_DATA: begin
               if (count_ff == LEN_W'(0)) begin
                  func_in = rx_byte;
               end else if (count_ff == LEN_W'(1)) begin
                  led_num_in = rx_byte;
               end else if (count_ff == LEN_W'(2)) begin
                  led_state_in = rx_byte;
               end
               xor_in   = xor_ff ^ rx_byte;
               count_in = count_inc;
               if (count_inc >= frame_len_ff) begin
                  phase_in = PH_SUM;
               end
            end
            PH_SUM: begin
               result.valid = (xor_ff == rx_byte);
               phase_in     = PH_HUNT;
               xor_in       = 8'h00;
            end
            default: begin
               if (rx_byte == HDR_FIRST) begin
                  phase_in = PH_HDR2;
                  xor_in   = rx_byte;
               end else begin
                  phase_in = PH_HUNT;
                  xor_in   = 8'h00;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HUNT;
         frame_len_ff <= '0;
         count_ff     <= '0;
         xor_ff       <= 8'h00;
         func_ff      <= 8'h00;
         led_num_ff   <= 8'h00;
         led_state_ff <= 8'h00;
      end else begin
         phase_ff     <= phase_in;
         frame_len_ff <= frame_len_in;
         count_ff     <= count_in;
         xor_ff       <= xor_in;
         func_ff      <= func_in;
         led_num_ff   <= led_num_in;
         led_state_ff <= led_state_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/xcfp_out_reg.sv =====
`timescale 1ns / 1ps
`default_nettype none

module xcfp_out_reg
   import xcfp_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire result_type result,
   output logic            open,
   output logic            out_valid,
   input  wire logic       out_ready,
   output rsp_type         out_data
);

   logic    valid_ff, valid_in;
   rsp_type data_ff,  data_in;

   assign open = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (open) begin
         valid_in = result.valid;
      end
      if (open && result.valid) begin
         data_in = result.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/xor_checked_frame_parser_top.sv =====
// A frame's result beat is registered and appears on the cycle after its checksum byte is taken.
// The parser takes one byte per cycle while req_ready is high; the frame state is updated for each byte taken.
// A byte is refused only while a result beat waits in the output register and rsp_ready is low.
// Reset is synchronous and active high; it returns the parser to hunting for the first header byte.
`timescale 1ns / 1ps
`default_nettype none

module xor_checked_frame_parser_top
   import xcfp_pkg::*;
#(
   parameter int MAX_DATA_LEN = 7
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_rx_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_func_code,
   output logic [2:0]      rsp_data_length,
   output logic            rsp_led_cmd,
   output logic [7:0]      rsp_led_index,
   output logic            rsp_led_on
);

   result_type result;
   rsp_type    out_data;
   logic       open;

   assign req_ready = open;

   xcfp_parser #(
      .MAX_DATA_LEN(MAX_DATA_LEN)
   ) u_parser (
      .clock  (clock),
      .reset  (reset),
      .take   (req_valid && open),
      .rx_byte(req_rx_byte),
      .result (result)
   );

   xcfp_out_reg u_out_reg (
      .clock    (clock),
      .reset    (reset),
      .result   (result),
      .open     (open),
      .out_valid(rsp_valid),
      .out_ready(rsp_ready),
      .out_data (out_data)
   );

   assign rsp_func_code   = out_data.func_code;
   assign rsp_data_length = out_data.data_length;
   assign rsp_led_cmd     = out_data.led_cmd;
   assign rsp_led_index   = out_data.led_index;
   assign rsp_led_on      = out_data.led_on;

endmodule

`default_nettype wire
